>>> design/hdrtm_pkg.sv
// Shared types and constants for the HDR half-float tone mapping pixel core.
// Holds the Reinhard/gamma decision thresholds, worked out at elaboration.
// No dependencies.
package hdrtm_pkg;

  // Fixed-point channel value: 16 integer and 24 fraction bits, plus one
  // extra bit so that positive infinity can sit above every threshold.
  localparam int XW        = 41;
  localparam int FRAC_BITS = 24;
  localparam int BYTE_W    = 8;
  localparam int NUM_CODES = 256;
  localparam int BIG_W     = 320;
  localparam int HALF_W    = 16;
  localparam int EXP_W     = 5;
  localparam int MANT_W    = 10;

  localparam logic [EXP_W-1:0] EXP_SPECIAL = 5'h1F;
  localparam logic [EXP_W-1:0] EXP_SUBNORM = 5'h00;

  typedef logic [XW-1:0]     xfix_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [HALF_W-1:0] half_t;
  typedef logic [NUM_CODES-1:0][XW-1:0] thr_tab_t;

  function automatic logic [BIG_W-1:0] big_pow(logic [BIG_W-1:0] b, int n);
    logic [BIG_W-1:0] r;
    r = BIG_W'(1);
    for (int i = 0; i < n; i++) begin
      r = r * b;
    end
    return r;
  endfunction

  // True when 255 * (x/(1+x))^(5/11) >= k - 1/2, in exact integer form.
  function automatic logic tm_pred(logic [XW-1:0] x, int k);
    logic [BIG_W-1:0] lhs;
    logic [BIG_W-1:0] rhs;
    lhs = big_pow(BIG_W'(x), 5) * big_pow(BIG_W'(510), 11);
    rhs = big_pow(BIG_W'(2 * k - 1), 11) *
          big_pow(BIG_W'(x) + (BIG_W'(1) << FRAC_BITS), 5);
    return (lhs >= rhs);
  endfunction

  // Entry k is the smallest value whose byte is at least k. Codes that no
  // finite input can reach get 2^40, which only infinity passes.
  function automatic thr_tab_t build_thresholds();
    thr_tab_t         tab;
    logic [XW-1:0]    lo;
    logic [XW-1:0]    hi;
    logic [XW:0]      sum;
    logic [XW-1:0]    mid;
    tab = '0;
    for (int k = 1; k < NUM_CODES; k++) begin
      lo = '0;
      hi = XW'(1) << (XW - 1);
      while (lo < hi) begin
        sum = {1'b0, lo} + {1'b0, hi};
        mid = sum[XW:1];
        if (tm_pred(mid, k)) begin
          hi = mid;
        end else begin
          lo = mid + XW'(1);
        end
      end
      tab[k] = lo;
    end
    return tab;
  endfunction

  localparam thr_tab_t THRESH = build_thresholds();

endpackage

>>> design/hdr_half_tonemap_pixel_core.sv
// Top level of the HDR half-float tone mapping pixel core.
// Depends on hdrtm_pkg for the threshold table and the channel types.
// A pixel accepted at the input reaches the outputs through nine register
// stages. Throughput: one pixel per clock while out_stall is low, set by
// the one-compare-per-stage search.
// Reset (rst_n, synchronous, active low) empties every pipeline stage.
// The core keeps no other state and needs no clearing pass.
module hdr_half_tonemap_pixel_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hdrtm_pkg::half_t    in_red_half,
  input  hdrtm_pkg::half_t    in_green_half,
  input  hdrtm_pkg::half_t    in_blue_half,
  output logic                out_valid,
  input  logic                out_stall,
  output hdrtm_pkg::byte_t    out_blue_byte,
  output hdrtm_pkg::byte_t    out_green_byte,
  output hdrtm_pkg::byte_t    out_red_byte
);
  import hdrtm_pkg::*;

  // Each channel is decoded to fixed point in stage 0. The byte is then the
  // largest code k whose threshold the value reaches; the thresholds rise
  // with k, so an eight-step binary search finds it, one bit per stage.
  // Stage j (1..8) settles bit 8-j of the byte. Stage 8 is the output.
  localparam int NSTG = BYTE_W + 1;
  localparam int NCH  = 3;

  // Decode one binary16 pattern. Negative patterns and NaN become zero;
  // positive infinity becomes all ones, above every threshold.
  function automatic xfix_t decode_half(half_t h);
    logic [EXP_W-1:0]  expo;
    logic [MANT_W-1:0] mant;
    xfix_t             x;
    expo = h[HALF_W-2:MANT_W];
    mant = h[MANT_W-1:0];
    if (h[HALF_W-1]) begin
      x = '0;
    end else if (expo == EXP_SPECIAL) begin
      x = (mant == '0) ? '1 : '0;
    end else if (expo == EXP_SUBNORM) begin
      x = XW'(mant);
    end else begin
      x = XW'({1'b1, mant}) << (expo - EXP_W'(1));
    end
    return x;
  endfunction

  logic              v_r   [NSTG];
  logic              ld    [NSTG];
  logic              rdy   [NSTG + 1];
  xfix_t             x_r   [NSTG - 1][NCH];
  byte_t             acc_r [1:NSTG - 1][NCH];
  half_t             in_ch [NCH];

  assign in_ch[0] = in_red_half;
  assign in_ch[1] = in_green_half;
  assign in_ch[2] = in_blue_half;

  // A stage may take new data when it is empty or its contents move on this
  // cycle, so bubbles close up and the input keeps flowing behind a stalled
  // result.
  always_comb begin
    rdy[NSTG] = !out_stall;
    for (int j = NSTG - 1; j >= 0; j--) begin
      rdy[j] = !v_r[j] || rdy[j + 1];
    end
  end

  always_comb begin
    ld[0] = rdy[0] && in_valid;
    for (int j = 1; j < NSTG; j++) begin
      ld[j] = rdy[j] && v_r[j - 1];
    end
  end

  assign in_stall = !rdy[0];

  // Valid bits for every stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NSTG; j++) begin
        v_r[j] <= 1'b0;
      end
    end else begin
      v_r[0] <= ld[0] ? 1'b1 : (v_r[0] && !rdy[1]);
      for (int j = 1; j < NSTG; j++) begin
        if (rdy[j]) begin
          v_r[j] <= v_r[j - 1];
        end
      end
    end
  end

  // Stage 0: decode.
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int c = 0; c < NCH; c++) begin
        x_r[0][c] <= decode_half(in_ch[c]);
      end
    end
  end

  // Search stages.
  for (genvar j = 1; j < NSTG; j++) begin : g_stage
    for (genvar c = 0; c < NCH; c++) begin : g_ch
      byte_t prev;
      byte_t cand;
      byte_t nxt;

      if (j == 1) begin : g_first
        assign prev = '0;
      end else begin : g_rest
        assign prev = acc_r[j - 1][c];
      end

      assign cand = prev | (BYTE_W'(1) << (BYTE_W - j));
      assign nxt  = (x_r[j - 1][c] >= THRESH[cand]) ? cand : prev;

      always_ff @(posedge clk) begin
        if (ld[j]) begin
          acc_r[j][c] <= nxt;
        end
      end

      if (j < NSTG - 1) begin : g_carry
        always_ff @(posedge clk) begin
          if (ld[j]) begin
            x_r[j][c] <= x_r[j - 1][c];
          end
        end
      end
    end
  end

  // The last stage holds the finished bytes, sent in blue, green, red order.
  assign out_valid      = v_r[NSTG - 1];
  assign out_red_byte   = acc_r[NSTG - 1][0];
  assign out_green_byte = acc_r[NSTG - 1][1];
  assign out_blue_byte  = acc_r[NSTG - 1][2];

endmodule

>>> tb/sv/testbench.sv
// Testbench for hdr_half_tonemap_pixel_core: Reinhard tone mapping with gamma 1/2.2
// of three binary16 channels into blue, green and red bytes.
// Depends on hdrtm_pkg for the port types and the half-float field constants.
`timescale 1ns / 100ps

module testbench;
  import hdrtm_pkg::*;

  // Wide enough for X^5 * 510^11 and (2k-1)^11 * (2^24 + X)^5.
  typedef logic [BIG_W-1:0] wide_t;

  // The expected bytes of one pixel, in the order in which the core emits them.
  typedef struct packed {
    byte_t blue;
    byte_t green;
    byte_t red;
  } bgr_t;

  // A selection of binary16 codes that sit on the edges of the decoding.
  localparam half_t HALF_POS_ZERO     = 16'h0000;
  localparam half_t HALF_NEG_ZERO     = 16'h8000;
  localparam half_t HALF_MIN_SUBNORM  = 16'h0001;
  localparam half_t HALF_MAX_SUBNORM  = 16'h03FF;
  localparam half_t HALF_MIN_NORMAL   = 16'h0400;
  localparam half_t HALF_ONE          = 16'h3C00;
  localparam half_t HALF_MAX_FINITE   = 16'h7BFF;
  localparam half_t HALF_POS_INF      = 16'h7C00;
  localparam half_t HALF_NEG_INF      = 16'hFC00;
  localparam half_t HALF_QUIET_NAN    = 16'h7E00;
  localparam half_t HALF_SIGNAL_NAN   = 16'h7C01;
  localparam half_t HALF_NEG_NAN      = 16'hFFFF;
  localparam half_t HALF_NEG_ONE      = 16'hBC00;
  localparam half_t HALF_NEG_SUBNORM  = 16'h8001;
  localparam half_t HALF_SMALL        = 16'h1C00;
  localparam half_t HALF_LARGE        = 16'h5BFF;

  // Cycles without a single accepted transaction on either side before the
  // run is declared hung, a generous margin over the longest pipeline drain.
  localparam int HANG_LIMIT = 1000;
  // Cycles to wait after the last result.
  localparam int TAIL_CYCLES = 20;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  half_t in_red_half = '0;
  half_t in_green_half = '0;
  half_t in_blue_half = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  byte_t out_blue_byte;
  byte_t out_green_byte;
  byte_t out_red_byte;

  // Expected pixels, oldest first, added when an input transaction is accepted.
  bgr_t  pending_bgr[$];
  int    mismatch_count = 0;
  // Chance in percent that a gap, or a stall burst, starts on a given cycle.
  int    gap_pct = 0;
  int    stall_pct = 0;
  int    stall_left = 0;

  hdr_half_tonemap_pixel_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_red_half    (in_red_half),
    .in_green_half  (in_green_half),
    .in_blue_half   (in_blue_half),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_blue_byte  (out_blue_byte),
    .out_green_byte (out_green_byte),
    .out_red_byte   (out_red_byte)
  );

  always #5 clk = ~clk;

  // Integer power by repeated squaring. Only the bits that matter are kept;
  // the last squaring may wrap, but its value is never used.
  function automatic wide_t wide_power(wide_t base, int exponent);
    wide_t acc;
    wide_t sq;
    int    n;
    acc = wide_t'(1);
    sq  = base;
    n   = exponent;
    while (n > 0) begin
      if (n[0]) begin
        acc = acc * sq;
      end
      sq = sq * sq;
      n  = n >> 1;
    end
    return acc;
  endfunction

  // Byte for one channel. The half value is first decoded exactly into X, the
  // value scaled by 2^24. The byte is the largest k for which
  // 255 * (x/(1+x))^(5/11) >= k - 1/2, which in whole numbers reads
  // X^5 * 510^11 >= (2k-1)^11 * (2^24 + X)^5. A binary search over k finds it.
  function automatic byte_t tonemap_byte(half_t h);
    logic [EXP_W-1:0]  expo;
    logic [MANT_W-1:0] mant;
    xfix_t             xv;
    wide_t             lhs;
    wide_t             den;
    wide_t             rhs;
    int                lo;
    int                hi;
    int                mid;
    expo = h[HALF_W-2 -: EXP_W];
    mant = h[MANT_W-1:0];
    // Anything with the sign bit set, NaN with a sign included, clamps to zero.
    if (h[HALF_W-1]) begin
      return '0;
    end
    // Positive infinity is the limit of the mapping; NaN clamps to zero.
    if (expo == EXP_SPECIAL) begin
      return (mant == '0) ? 8'd255 : 8'd0;
    end
    if (expo == EXP_SUBNORM) begin
      xv = xfix_t'(mant);
    end else begin
      xv = xfix_t'({1'b1, mant}) << (expo - 1);
    end
    if (xv == '0) begin
      return '0;
    end
    lhs = wide_power(wide_t'(xv), 5) * wide_power(wide_t'(510), 11);
    den = wide_power(wide_t'(xv) + (wide_t'(1) << FRAC_BITS), 5);
    lo  = 0;
    hi  = 255;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      rhs = wide_power(wide_t'(2 * mid - 1), 11) * den;
      if (lhs >= rhs) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return byte_t'(lo);
  endfunction

  function automatic bgr_t tonemap_pixel(half_t red, half_t green, half_t blue);
    bgr_t p;
    p.blue  = tonemap_byte(blue);
    p.green = tonemap_byte(green);
    p.red   = tonemap_byte(red);
    return p;
  endfunction

  // Draws a channel value. Most draws are positive and finite, where the bytes
  // actually vary; the rest are specials, negatives and fully random codes so
  // that every bit of the field is exercised.
  function automatic half_t random_half();
    half_t h;
    case ($urandom_range(0, 9))
      0, 1: begin
        h = half_t'($urandom_range(0, 65535));
      end
      2, 3, 4, 5, 6: begin
        h = {1'b0, EXP_W'($urandom_range(0, 30)), MANT_W'($urandom_range(0, 1023))};
      end
      7: begin
        // Dark end, where each step of x moves the byte furthest.
        h = {1'b0, EXP_W'($urandom_range(0, 15)), MANT_W'($urandom_range(0, 1023))};
      end
      8: begin
        case ($urandom_range(0, 3))
          0: h = HALF_POS_INF;
          1: h = HALF_NEG_INF;
          2: h = {1'($urandom_range(0, 1)), EXP_SPECIAL, MANT_W'($urandom_range(1, 1023))};
          default: h = {1'($urandom_range(0, 1)), 15'h0000};
        endcase
      end
      default: begin
        h = {1'b1, 15'($urandom_range(0, 32767))};
      end
    endcase
    return h;
  endfunction

  // Sends one pixel. An optional idle gap of random length comes first;
  // the payload is then held until the core takes the transaction, at which
  // point the expected bytes are queued.
  task automatic send_pixel(half_t red, half_t green, half_t blue);
    int gap;
    gap = 0;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 3);
    end
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_red_half   <= red;
    in_green_half <= green;
    in_blue_half  <= blue;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    pending_bgr = {pending_bgr, tonemap_pixel(red, green, blue)};
  endtask

  // Lowers valid and waits until every queued pixel has come out.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_bgr.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Every special code on every channel. The list is rotated by different
  // amounts per channel so that a swapped channel shows up at once.
  task automatic test_special_values();
    half_t codes[16];
    codes = '{HALF_POS_ZERO, HALF_NEG_ZERO, HALF_MIN_SUBNORM, HALF_MAX_SUBNORM,
              HALF_MIN_NORMAL, HALF_ONE, HALF_MAX_FINITE, HALF_POS_INF,
              HALF_NEG_INF, HALF_QUIET_NAN, HALF_SIGNAL_NAN, HALF_NEG_NAN,
              HALF_NEG_ONE, HALF_NEG_SUBNORM, HALF_SMALL, HALF_LARGE};
    gap_pct   = 0;
    stall_pct = 0;
    for (int i = 0; i < 16; i++) begin
      send_pixel(codes[i], codes[(i + 5) % 16], codes[(i + 11) % 16]);
    end
    // All three channels at full scale and all three at zero.
    send_pixel(HALF_POS_INF, HALF_POS_INF, HALF_POS_INF);
    send_pixel(HALF_POS_ZERO, HALF_POS_ZERO, HALF_POS_ZERO);
  endtask

  // The bulk of the random pixels. The idling rates on both sides change every
  // fifty transactions, with some stretches running without any idling.
  task automatic test_random_pixels();
    for (int i = 0; i < 500; i++) begin
      if (i % 50 == 0) begin
        gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
        stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
      end
      send_pixel(random_half(), random_half(), random_half());
    end
  endtask

  // The sender stops now and then until the pipeline has fully drained, so
  // that the core restarts from empty in the middle of the stream.
  task automatic test_drain_pause();
    gap_pct   = 20;
    stall_pct = 30;
    for (int i = 0; i < 100; i++) begin
      if (i % 25 == 24) begin
        drain_results();
      end
      send_pixel(random_half(), random_half(), random_half());
    end
  endtask

  // Back to back at one pixel per clock with no idling on either side.
  task automatic test_full_rate();
    gap_pct   = 0;
    stall_pct = 0;
    for (int i = 0; i < 400; i++) begin
      send_pixel(random_half(), random_half(), random_half());
    end
  endtask

  // Result side stalls in bursts of random length.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if (rst_n && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 3) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Each accepted result transaction is checked against the oldest expected
  // pixel, byte by byte.
  always @(posedge clk) begin
    bgr_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bgr.size() == 0) begin
        $error("unexpected result transaction: blue %0d green %0d red %0d",
               out_blue_byte, out_green_byte, out_red_byte);
        mismatch_count++;
      end else begin
        want = pending_bgr.pop_front();
        if (out_blue_byte !== want.blue) begin
          $error("out_blue_byte: expected %0d, got %0d", want.blue, out_blue_byte);
          mismatch_count++;
        end
        if (out_green_byte !== want.green) begin
          $error("out_green_byte: expected %0d, got %0d", want.green, out_green_byte);
          mismatch_count++;
        end
        if (out_red_byte !== want.red) begin
          $error("out_red_byte: expected %0d, got %0d", want.red, out_red_byte);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: ends the run if no transaction moves on either side for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_special_values();
    test_random_pixels();
    test_drain_pause();
    test_full_rate();

    // Everything sent: wait for the last results, then a short tail in which
    // any stray result transaction would be caught by the checker.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_bgr.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
